### src/wildcard_pattern_matcher_assert.svh
// Assertion macros used by the wildcard matcher top level.
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define WPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that, once seen, must be followed by another in the next cycle.
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/wpm_pkg.sv
// Package: constants, types and helpers for the wildcard matcher.
package wpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int POS_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_SUBJECT = 2'd2,
        ACT_END     = 2'd3
    } wpm_action_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic       rearm;     // return active vector to its armed value
        logic       step;      // advance on a subject byte
        logic [7:0] char_code; // raw byte of the current request
    } wpm_ctrl_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### src/wpm_cell.sv
// One pattern position: stored pattern byte and its active bit.
module wpm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  wpm_pkg::wpm_ctrl_t ctrl,
    input  logic              load_here, // pattern byte lands in this cell
    input  logic              used,      // cell lies below the pattern length
    input  logic              arm_val,   // active value right after a rearm
    input  logic              carry_in,  // star closure from left neighbor
    input  logic              adv_in,    // left neighbor consumed a byte
    output logic              carry_out,
    output logic              adv_out,
    output logic              raw,       // stored active bit, before closure
    output logic              closed     // active bit after star closure
);
    import wpm_pkg::*;

    logic [7:0] fold_reg;
    logic       star_reg;
    logic       quest_reg;
    // Stored as the difference from the armed value so reset is a plain clear.
    logic       dev_reg;
    logic       dev_next;
    logic       raw_next;
    logic       hit;

    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            fold_reg  <= fold_case(ctrl.char_code);
            star_reg  <= (ctrl.char_code == CH_STAR);
            quest_reg <= (ctrl.char_code == CH_QUEST);
        end
    end

    assign raw       = dev_reg ^ arm_val;
    assign closed    = raw | carry_in;
    assign carry_out = closed & used & star_reg;
    assign hit       = quest_reg | (fold_reg == fold_case(ctrl.char_code));
    assign adv_out   = closed & used & !star_reg & hit;

    always_comb
    begin
        raw_next = raw;
        if (ctrl.rearm)
        begin
            raw_next = arm_val;
        end
        else if (ctrl.step)
        begin
            // a star keeps its own position on any byte
            raw_next = adv_in | (closed & used & star_reg);
        end
        dev_next = raw_next ^ arm_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= 1'b0;
        end
        else
        begin
            dev_reg <= dev_next;
        end
    end

endmodule

### src/wildcard_pattern_matcher.sv
// Top level of the case-insensitive glob wildcard matcher.
//
// Usage:
//   Requests arrive on the s_ channel. s_tuser carries the action (clear
//   pattern, append pattern byte, subject byte, end of subject) and s_tdata
//   the byte. A zero byte on append or subject is ignored. Clear, a nonzero
//   append and end of subject all re-arm the matcher; subject bytes advance
//   every pattern position in parallel through a row of cells.
//   Only end of subject produces a result on the m_ channel: bit 0 of
//   m_tdata is the match, bit 1 the pattern overflow flag.
// Throughput: one request per cycle on every action, but an end of subject
//   held by a pending result. Limit: star closure ripple through the cells.
// Latency: the result is registered and shows up the cycle after the end
//   of subject request is accepted.
// Stalls: while a result waits on a low m_tready, every request except a
//   further end of subject is still taken; that one waits for the slot.
// Reset: pattern empty, overflow clear, matcher armed, output empty. Stored
//   pattern bytes are not cleared and are only read below the length.
module wildcard_pattern_matcher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] char_code
    input  logic [1:0] s_tuser,  // [1:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);
    import wpm_pkg::*;

    localparam logic [MAX_PATTERN:0] RAW_ARM = (MAX_PATTERN + 1)'(1);
    localparam logic [POS_W-1:0]     LEN_MAX = POS_W'(MAX_PATTERN);

    wpm_action_t          action;
    logic                 acc;
    logic                 nz;
    logic                 clear_acc;
    logic                 append_acc;
    logic                 end_acc;
    logic                 full;
    wpm_ctrl_t            ctrl;

    logic [POS_W-1:0]     len_reg;
    logic [POS_W-1:0]     len_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 tail_raw_reg;
    logic                 tail_raw_next;

    logic [MAX_PATTERN:0]   carry;   // carry[j] enters cell j
    logic [MAX_PATTERN:0]   adv;
    logic [MAX_PATTERN:0]   raw_vec;
    logic [MAX_PATTERN:0]   closed_vec;

    logic                 m_tvalid_reg;
    logic                 m_matched_reg;
    logic                 m_ovf_reg;

    assign action = wpm_action_t'(s_tuser);
    assign nz     = (s_tdata != CH_NUL);
    assign full   = (len_reg == LEN_MAX);

    // Only a second result can collide with a pending one.
    assign s_tready = !(m_tvalid_reg && !m_tready && (action == ACT_END));
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        clear_acc  = 1'b0;
        append_acc = 1'b0;
        end_acc    = 1'b0;
        ctrl.step  = 1'b0;
        unique case (action)
            ACT_CLEAR:   clear_acc  = acc;
            ACT_APPEND:  append_acc = acc && nz;
            ACT_SUBJECT: ctrl.step  = acc && nz;
            ACT_END:     end_acc    = acc;
            default:     ;
        endcase
        ctrl.rearm     = clear_acc || append_acc || end_acc;
        ctrl.char_code = s_tdata;
    end

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (clear_acc)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (append_acc)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                len_next = len_reg + POS_W'(1);
            end
        end
    end

    // Cell row. Cell 0 starts active, the others idle.
    assign carry[0] = 1'b0;
    assign adv[0]   = 1'b0;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        wpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load_here (append_acc && !full && (len_reg == POS_W'(j))),
            .used      (POS_W'(j) < len_reg),
            .arm_val   (RAW_ARM[j]),
            .carry_in  (carry[j]),
            .adv_in    (adv[j]),
            .carry_out (carry[j+1]),
            .adv_out   (adv[j+1]),
            .raw       (raw_vec[j]),
            .closed    (closed_vec[j])
        );
    end

    // Position past the last cell: the accepting position for a full pattern.
    assign raw_vec[MAX_PATTERN]    = tail_raw_reg;
    assign closed_vec[MAX_PATTERN] = tail_raw_reg | carry[MAX_PATTERN];

    always_comb
    begin
        tail_raw_next = tail_raw_reg;
        if (ctrl.rearm)
        begin
            tail_raw_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            tail_raw_next = adv[MAX_PATTERN];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            tail_raw_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
            tail_raw_reg <= tail_raw_next;
            if (end_acc)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_acc)
        begin
            m_matched_reg <= closed_vec[len_reg];
            m_ovf_reg     <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, m_matched_reg};

    `include "wildcard_pattern_matcher_assert.svh"

    `WPM_ASSERT_NEXT(a_clear_empties, clear_acc, (len_reg == '0) && !ovf_reg, "clear left pattern")
    `WPM_ASSERT(a_len_bound, len_reg <= LEN_MAX, "pattern length past capacity")
    `WPM_ASSERT_NEXT(a_rearm_raw, ctrl.rearm, raw_vec == RAW_ARM, "rearm left stale positions")
    `WPM_ASSERT(a_ovf_full, $rose(ovf_reg) |-> full, "overflow set below capacity")
    `WPM_ASSERT(a_out_cause, $rose(m_tvalid_reg) |-> $past(end_acc), "result without end request")

endmodule
